### hdl/sfd_pkg.sv
package sfd_pkg;

  localparam int SLOTS_DEF = 5;

  localparam int IDX_W   = 3;
  localparam int CNT_W   = 16;
  localparam int RATIO_W = 9;
  localparam int RUN_W   = 8;
  localparam int METER_W = 3;
  localparam int CFG_IDX_W = 2;

  localparam int METER_MAX = 7;

  localparam logic [RATIO_W-1:0] MIN_FILL_RST = 9'd128;
  localparam logic [RATIO_W-1:0] MAX_FILL_RST = 9'd256;
  localparam logic [RUN_W-1:0]   ON_NEED_RST  = 8'd2;
  localparam logic [RUN_W-1:0]   OFF_NEED_RST = 8'd2;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MIN_FILL = 2'd0,
    REG_MAX_FILL = 2'd1,
    REG_ON_NEED  = 2'd2,
    REG_OFF_NEED = 2'd3
  } reg_idx_t;

  typedef struct packed {
    logic [RATIO_W-1:0] min_fill_q8;
    logic [RATIO_W-1:0] max_fill_q8;
    logic [RUN_W-1:0]   on_run_req;
    logic [RUN_W-1:0]   off_run_req;
  } cfg_t;

  // item leaving the update stage
  typedef struct packed {
    logic valid;
    logic last;
  } done_t;

endpackage

### hdl/sfd_in_if.sv
interface sfd_in_if;
  import sfd_pkg::*;

  logic               valid;
  logic               ready;
  logic [IDX_W-1:0]   slot_index;
  logic [CNT_W-1:0]   white_count;
  logic [CNT_W-1:0]   pixel_area;
  logic               last_slot;

  modport source (output valid, slot_index, white_count, pixel_area, last_slot,
                  input ready);
  modport sink   (input valid, slot_index, white_count, pixel_area, last_slot,
                  output ready);
endinterface

### hdl/sfd_out_if.sv
interface sfd_out_if;
  import sfd_pkg::*;

  logic               valid;
  logic               ready;
  logic [METER_W-1:0] meter_value;

  modport source (output valid, meter_value, input ready);
  modport sink   (input valid, meter_value, output ready);
endinterface

### hdl/sfd_cfg_if.sv
interface sfd_cfg_if;
  import sfd_pkg::*;

  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [RATIO_W-1:0]   data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

### hdl/sfd_cfg_regs.sv
module sfd_cfg_regs (
  input  logic         clk,
  input  logic         rst_n,
  sfd_cfg_if.sink      cfg_ch,
  output sfd_pkg::cfg_t cfg
);
  import sfd_pkg::*;

  cfg_t cfg_r;

  assign cfg_ch.ready = 1'b1;
  assign cfg          = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.min_fill_q8 <= MIN_FILL_RST;
      cfg_r.max_fill_q8 <= MAX_FILL_RST;
      cfg_r.on_run_req  <= ON_NEED_RST;
      cfg_r.off_run_req <= OFF_NEED_RST;
    end else if (cfg_ch.valid) begin
      case (reg_idx_t'(cfg_ch.index))
        REG_MIN_FILL: cfg_r.min_fill_q8 <= cfg_ch.data;
        REG_MAX_FILL: cfg_r.max_fill_q8 <= cfg_ch.data;
        REG_ON_NEED:  cfg_r.on_run_req  <= cfg_ch.data[RUN_W-1:0];
        REG_OFF_NEED: cfg_r.off_run_req <= cfg_ch.data[RUN_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

### hdl/sfd_slot_pipe.sv
module sfd_slot_pipe #(
  parameter int SLOTS = sfd_pkg::SLOTS_DEF
) (
  input  logic           clk,
  input  logic           rst_n,
  input  sfd_pkg::cfg_t  cfg,
  sfd_in_if.sink         in_ch,
  input  logic           take,
  output sfd_pkg::done_t done,
  output logic [SLOTS-1:0] filled
);
  import sfd_pkg::*;

  localparam int IW    = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int PW    = CNT_W + RATIO_W;
  localparam int ENT_W = 2 * RUN_W;

  function automatic logic [RUN_W-1:0] sat_inc(input logic [RUN_W-1:0] v);
    return (v == {RUN_W{1'b1}}) ? v : v + 1'b1;
  endfunction

  // counter memory, entry = {on_run, off_run}
  logic [ENT_W-1:0] mem [SLOTS];
  logic [ENT_W-1:0] rd_q_r;

  logic [SLOTS-1:0] ent_v_r;
  logic [SLOTS-1:0] filled_r;

  // stage 1
  logic             p1_v_r;
  logic [IDX_W-1:0] p1_idx_r;
  logic [CNT_W-1:0] p1_white_r;
  logic [CNT_W-1:0] p1_area_r;
  logic             p1_last_r;

  // stage 2
  logic             p2_v_r;
  logic             p2_hit_r;
  logic [IW-1:0]    p2_addr_r;
  logic             p2_last_r;
  logic [PW-1:0]    p2_w_r;
  logic [PW-1:0]    p2_lo_r;
  logic [PW-1:0]    p2_hi_r;
  logic             p2_ev_r;
  logic             p2_fwd_r;
  logic [ENT_W-1:0] p2_fwd_d_r;

  logic             p1_adv, p2_adv, p1_hit, wr_en, raw, flag_nxt;
  logic [IW-1:0]    p1_addr;
  logic [ENT_W-1:0] cur, wr_data;
  logic [RUN_W-1:0] on_cur, off_cur, on_nxt, off_nxt;

  assign p2_adv      = p2_v_r && take;
  assign p1_adv      = p1_v_r && (!p2_v_r || p2_adv);
  assign in_ch.ready = !p1_v_r || p1_adv;

  assign p1_addr = IW'(p1_idx_r);
  assign p1_hit  = (32'(p1_idx_r) < SLOTS) && (p1_area_r != '0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p1_v_r <= 1'b0;
    end else if (in_ch.ready) begin
      p1_v_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      p1_idx_r   <= in_ch.slot_index;
      p1_white_r <= in_ch.white_count;
      p1_area_r  <= in_ch.pixel_area;
      p1_last_r  <= in_ch.last_slot;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p2_v_r <= 1'b0;
    end else if (!p2_v_r || p2_adv) begin
      p2_v_r <= p1_v_r;
    end
  end

  // bound products and forwarding from the write in flight
  always_ff @(posedge clk) begin
    if (p1_adv) begin
      p2_hit_r   <= p1_hit;
      p2_addr_r  <= p1_addr;
      p2_last_r  <= p1_last_r;
      p2_w_r     <= PW'({p1_white_r, 8'h00});
      p2_lo_r    <= PW'(cfg.min_fill_q8) * PW'(p1_area_r);
      p2_hi_r    <= PW'(cfg.max_fill_q8) * PW'(p1_area_r);
      p2_ev_r    <= p1_hit ? ent_v_r[p1_addr] : 1'b0;
      p2_fwd_r   <= wr_en && (p2_addr_r == p1_addr);
      p2_fwd_d_r <= wr_data;
    end
  end

  assign cur     = p2_fwd_r ? p2_fwd_d_r : (p2_ev_r ? rd_q_r : '0);
  assign on_cur  = cur[ENT_W-1:RUN_W];
  assign off_cur = cur[RUN_W-1:0];
  assign raw     = (p2_w_r >= p2_lo_r) && (p2_w_r <= p2_hi_r);

  always_comb begin
    if (raw) begin
      on_nxt   = sat_inc(on_cur);
      off_nxt  = '0;
      flag_nxt = filled_r[p2_addr_r] || (on_nxt >= cfg.on_run_req);
    end else begin
      on_nxt   = '0;
      off_nxt  = sat_inc(off_cur);
      flag_nxt = filled_r[p2_addr_r] && !(off_nxt >= cfg.off_run_req);
    end
  end

  assign wr_en   = p2_adv && p2_hit_r;
  assign wr_data = {on_nxt, off_nxt};

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[p2_addr_r] <= wr_data;
    end
    if (p1_adv && p1_hit) begin
      rd_q_r <= mem[p1_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ent_v_r  <= '0;
      filled_r <= '0;
    end else if (wr_en) begin
      ent_v_r[p2_addr_r]  <= 1'b1;
      filled_r[p2_addr_r] <= flag_nxt;
    end
  end

  assign done.valid = p2_v_r;
  assign done.last  = p2_last_r;
  assign filled     = filled_r;

`ifndef NO_ASSERTIONS
  a_flag_only_on_write: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) && !$stable(filled_r) |-> $past(wr_en))
    else $error("filled flags changed without a counter write");

  a_valid_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) |-> (($past(ent_v_r) & ~ent_v_r) == '0))
    else $error("entry valid bit dropped outside reset");

  a_flag_needs_entry: assert property (@(posedge clk) disable iff (!rst_n)
    (filled_r & ~ent_v_r) == '0)
    else $error("slot flagged filled with no counter entry written");

  a_fwd_same_entry: assert property (@(posedge clk) disable iff (!rst_n)
    p1_adv && wr_en && (p1_addr == p2_addr_r) |=> p2_fwd_r)
    else $error("read-after-write to one entry not forwarded");
`endif

endmodule

### hdl/slot_fill_debounce_meter.sv
// throughput: one slot transaction per cycle unless the output stalls,
// single read and single write port on the counter memory, with
// same-entry read-after-write forwarded
// reset (rst_n low, synchronous): config registers to defaults, filled flags and
// per-entry valid bits cleared, pipeline emptied; counter memory is not swept
module slot_fill_debounce_meter #(
  parameter int SLOTS = sfd_pkg::SLOTS_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  sfd_in_if.sink     in_ch,
  sfd_out_if.source  out_ch,
  sfd_cfg_if.sink    cfg_ch
);
  import sfd_pkg::*;

  cfg_t             cfg;
  done_t            done;
  logic [SLOTS-1:0] filled;

  // stage 3 marks a finished last slot; the flags then hold exactly its frame
  logic               p3_v_r;
  logic               out_v_r;
  logic [METER_W-1:0] meter_r;
  logic [METER_W-1:0] meter;
  logic               out_free, p3_take;

  // register file for ratio bounds and run thresholds
  sfd_cfg_regs u_cfg (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg_ch (cfg_ch),
    .cfg    (cfg)
  );

  // product stage, then counter read-modify-write and flag update
  sfd_slot_pipe #(.SLOTS(SLOTS)) u_pipe (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg    (cfg),
    .in_ch  (in_ch),
    .take   (p3_take),
    .done   (done),
    .filled (filled)
  );

  assign out_free = !out_v_r || out_ch.ready;
  assign p3_take  = !p3_v_r || out_free;

  // highest filled slot wins, clipped to what the output field holds
  always_comb begin
    meter = '0;
    for (int i = 0; i < SLOTS; i++) begin
      if (filled[i]) begin
        meter = (i + 1 > METER_MAX) ? METER_W'(METER_MAX) : METER_W'(i + 1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p3_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      if (p3_take) begin
        p3_v_r <= done.valid && done.last;
      end
      if (out_free) begin
        out_v_r <= p3_v_r;
      end
    end
  end

  // flags are sampled before the next slot's update lands
  always_ff @(posedge clk) begin
    if (out_free && p3_v_r) begin
      meter_r <= meter;
    end
  end

  assign out_ch.valid       = out_v_r;
  assign out_ch.meter_value = meter_r;

endmodule

### test/tb_slot_fill_debounce_meter.sv
module tb_slot_fill_debounce_meter;
  import sfd_pkg::*;

  localparam int N_SLOTS   = SLOTS_DEF;
  // margin after the last owed meter, for trailing slots to finish
  localparam int TAIL_CYC  = 8;
  // long output stall, enough to back the pipeline up into the input
  localparam int HOLD_CYC  = 80;
  localparam int RAND_ITEMS = 950;
  localparam int RUN_LEN   = 260;

  // one slot measurement as it travels on the input channel
  typedef struct packed {
    logic [IDX_W-1:0] slot_index;
    logic [CNT_W-1:0] white_count;
    logic [CNT_W-1:0] pixel_area;
    logic             last_slot;
  } slot_meas_t;

  // tracks per-slot debounce state and the meter readings still owed
  class meter_tracker;
    cfg_t               cfg;
    logic               filled [N_SLOTS];
    logic [RUN_W-1:0]   on_run [N_SLOTS];
    logic [RUN_W-1:0]   off_run [N_SLOTS];
    logic [METER_W-1:0] expected_meters [$];
    int                 errors;

    function new();
      cfg.min_fill_q8 = MIN_FILL_RST;
      cfg.max_fill_q8 = MAX_FILL_RST;
      cfg.on_run_req  = ON_NEED_RST;
      cfg.off_run_req = OFF_NEED_RST;
      for (int i = 0; i < N_SLOTS; i++) begin
        filled[i]  = 1'b0;
        on_run[i]  = '0;
        off_run[i] = '0;
      end
      errors = 0;
    endfunction

    function void apply_reg(reg_idx_t r, logic [RATIO_W-1:0] d);
      case (r)
        REG_MIN_FILL: cfg.min_fill_q8 = d;
        REG_MAX_FILL: cfg.max_fill_q8 = d;
        REG_ON_NEED:  cfg.on_run_req  = d[RUN_W-1:0];
        REG_OFF_NEED: cfg.off_run_req = d[RUN_W-1:0];
        default: ;
      endcase
    endfunction

    // exact Q8 ratio window test
    function bit ratio_in_window(logic [CNT_W-1:0] white, logic [CNT_W-1:0] area);
      logic [31:0] scaled;
      logic [31:0] lo_bound;
      logic [31:0] hi_bound;
      scaled   = {8'h00, white, 8'h00};
      lo_bound = 32'(cfg.min_fill_q8) * 32'(area);
      hi_bound = 32'(cfg.max_fill_q8) * 32'(area);
      return (scaled >= lo_bound) && (scaled <= hi_bound);
    endfunction

    function void note_slot(slot_meas_t m);
      int s;
      int mv;
      if (m.slot_index < N_SLOTS && m.pixel_area != 0) begin
        s = m.slot_index;
        if (ratio_in_window(m.white_count, m.pixel_area)) begin
          if (on_run[s] != '1) on_run[s] = on_run[s] + 1'b1;
          off_run[s] = '0;
          if (on_run[s] >= cfg.on_run_req) filled[s] = 1'b1;
        end else begin
          if (off_run[s] != '1) off_run[s] = off_run[s] + 1'b1;
          on_run[s] = '0;
          if (off_run[s] >= cfg.off_run_req) filled[s] = 1'b0;
        end
      end
      if (m.last_slot) begin
        mv = 0;
        for (int i = 0; i < N_SLOTS; i++)
          if (filled[i]) mv = (i + 1 > METER_MAX) ? METER_MAX : i + 1;
        expected_meters.push_back(METER_W'(mv));
      end
    endfunction

    function void check_meter(logic [METER_W-1:0] got);
      logic [METER_W-1:0] want;
      if (expected_meters.size() == 0) begin
        $display("%0t: meter_value mismatch, expected none, actual %0d", $time, got);
        errors++;
      end else begin
        want = expected_meters.pop_front();
        if (want !== got) begin
          $display("%0t: meter_value mismatch, expected %0d, actual %0d", $time, want, got);
          errors++;
        end
      end
    endfunction

    function int pending();
      return expected_meters.size();
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  sfd_in_if  in_ch ();
  sfd_out_if out_ch ();
  sfd_cfg_if cfg_ch ();

  slot_fill_debounce_meter dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  meter_tracker sb;

  // idling switches per phase, and the request for one long output stall
  bit in_idle;
  bit out_idle;
  bit hold_req;
  int items_sent;
  bit fill_trend [N_SLOTS];

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // safety net against a hung handshake
  initial begin
    #8000000;
    $display("tb_slot_fill_debounce_meter: done, errors");
    $finish;
  end

  // monitor: results are checked before the same-edge input is noted,
  // a result can never belong to an input accepted at the same edge
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_ch.valid && out_ch.ready) sb.check_meter(out_ch.meter_value);
      if (in_ch.valid && in_ch.ready)
        sb.note_slot({in_ch.slot_index, in_ch.white_count, in_ch.pixel_area,
                      in_ch.last_slot});
    end
  end

  // result receiver: random ready gaps per result, one long hold on request
  initial begin : receiver
    int gap;
    out_ch.ready = 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        gap = HOLD_CYC;
      end else begin
        gap = out_idle ? $urandom_range(0, 7) : 0;
      end
      if (gap > 0) begin
        out_ch.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      @(posedge clk);
      while (!out_ch.valid) @(posedge clk);
    end
  end

  function automatic slot_meas_t mk(int idx, int white, int area, bit last);
    slot_meas_t m;
    m.slot_index  = IDX_W'(idx);
    m.white_count = CNT_W'(white);
    m.pixel_area  = CNT_W'(area);
    m.last_slot   = last;
    return m;
  endfunction

  // random measurement that lands inside or outside the current fill window
  function automatic slot_meas_t make_meas(logic [IDX_W-1:0] slot, bit want_fill, bit last);
    slot_meas_t m;
    logic [31:0] area32;
    logic [31:0] lo;
    logic [31:0] hi;
    logic [31:0] top;
    m.slot_index = slot;
    m.last_slot  = last;
    case ($urandom_range(0, 3))
      0:       m.pixel_area = CNT_W'($urandom_range(1, 16));
      1:       m.pixel_area = CNT_W'($urandom_range(1, 1024));
      2:       m.pixel_area = CNT_W'($urandom_range(1, 65535));
      default: m.pixel_area = '1;
    endcase
    area32 = 32'(m.pixel_area);
    // white window that passes: ceil(min*area/256) .. floor(max*area/256)
    lo = (32'(sb.cfg.min_fill_q8) * area32 + 32'd255) >> 8;
    hi = (32'(sb.cfg.max_fill_q8) * area32) >> 8;
    if (hi > 32'hFFFF) hi = 32'hFFFF;
    m.white_count = CNT_W'($urandom);
    if (want_fill) begin
      if (lo <= hi) begin
        if ($urandom_range(0, 3) == 0)
          m.white_count = $urandom_range(0, 1) ? lo[CNT_W-1:0] : hi[CNT_W-1:0];
        else
          m.white_count = CNT_W'($urandom_range(hi, lo));
      end
    end else if ($urandom_range(0, 9) != 0) begin
      if (lo != 0 && (hi >= 32'hFFFF || $urandom_range(0, 1) == 1)) begin
        top = (lo - 1 > 32'hFFFF) ? 32'hFFFF : lo - 1;
        m.white_count = ($urandom_range(0, 3) == 0) ? top[CNT_W-1:0]
                                                     : CNT_W'($urandom_range(top, 0));
      end else if (hi < 32'hFFFF) begin
        m.white_count = ($urandom_range(0, 3) == 0) ? CNT_W'(hi + 1)
                                                     : CNT_W'($urandom_range(32'hFFFF, hi + 1));
      end
    end
    return m;
  endfunction

  // valid stays high from one transaction to the next when there is no gap
  task automatic send_slot(slot_meas_t m);
    int gap;
    gap = in_idle ? $urandom_range(0, 7) : 0;
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid       <= 1'b1;
    in_ch.slot_index  <= m.slot_index;
    in_ch.white_count <= m.white_count;
    in_ch.pixel_area  <= m.pixel_area;
    in_ch.last_slot   <= m.last_slot;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    items_sent++;
  endtask

  task automatic cfg_write(reg_idx_t r, logic [RATIO_W-1:0] d);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= r;
    cfg_ch.data  <= d;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    sb.apply_reg(r, d);
  endtask

  task automatic set_config(logic [RATIO_W-1:0] min_q8, logic [RATIO_W-1:0] max_q8,
                            logic [RATIO_W-1:0] on_need, logic [RATIO_W-1:0] off_need);
    cfg_write(REG_MIN_FILL, min_q8);
    cfg_write(REG_MAX_FILL, max_q8);
    cfg_write(REG_ON_NEED, on_need);
    cfg_write(REG_OFF_NEED, off_need);
    cfg_ch.valid <= 1'b0;
  endtask

  // stop sending, let every owed meter arrive, then let trailing slots finish
  task automatic settle();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (TAIL_CYC) @(posedge clk);
  endtask

  // frames of slots 0..N-1 with slowly flipping fill trends, plus some noise:
  // skipped slots, out-of-range indexes, stray slots, broken frame ends
  task automatic run_frames(int nframes);
    slot_meas_t m;
    int r;
    for (int f = 0; f < nframes; f++) begin
      for (int s = 0; s < N_SLOTS; s++) begin
        if ($urandom_range(0, 5) == 0) fill_trend[s] = !fill_trend[s];
        r = $urandom_range(0, 19);
        if (r == 0) begin
          m = make_meas(IDX_W'(s), fill_trend[s], 1'b0);
          m.pixel_area = '0;
        end else if (r == 1) begin
          m = make_meas(IDX_W'($urandom_range(N_SLOTS, 7)), 1'b1, 1'b0);
        end else if (r == 2) begin
          m = make_meas(IDX_W'($urandom_range(0, N_SLOTS - 1)), 1'b0, 1'b0);
          m.white_count = CNT_W'($urandom);
        end else begin
          m = make_meas(IDX_W'(s), fill_trend[s], 1'b0);
        end
        m.last_slot = (s == N_SLOTS - 1) ? ($urandom_range(0, 29) != 0)
                                         : ($urandom_range(0, 29) == 0);
        send_slot(m);
      end
    end
  endtask

  // long same-slot run to push the run counters into saturation
  task automatic long_run(int slot, bit want_fill);
    for (int k = 0; k < RUN_LEN; k++)
      send_slot(make_meas(IDX_W'(slot), want_fill, (k % 64 == 63) || (k == RUN_LEN - 1)));
  endtask

  initial begin : stimulus
    int ph;
    logic [RATIO_W-1:0] min_q8;
    logic [RATIO_W-1:0] max_q8;
    sb = new();
    in_idle    = 1'b0;
    out_idle   = 1'b0;
    hold_req   = 1'b0;
    items_sent = 0;
    for (int i = 0; i < N_SLOTS; i++) fill_trend[i] = 1'b0;
    in_ch.valid       = 1'b0;
    in_ch.slot_index  = '0;
    in_ch.white_count = '0;
    in_ch.pixel_area  = '0;
    in_ch.last_slot   = 1'b0;
    cfg_ch.valid      = 1'b0;
    cfg_ch.index      = REG_MIN_FILL;
    cfg_ch.data       = '0;

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: reset config, full-scale values, exact window edges,
    // white above area, zero area, out-of-range slots
    send_slot(mk(0, 65535, 65535, 0));
    send_slot(mk(0, 65535, 65535, 1));
    send_slot(mk(4, 0, 65535, 0));
    send_slot(mk(4, 65535, 1, 1));
    send_slot(mk(4, 128, 256, 0));
    send_slot(mk(4, 256, 256, 1));
    send_slot(mk(4, 65535, 0, 1));
    send_slot(mk(5, 0, 100, 0));
    send_slot(mk(7, 100, 100, 1));
    send_slot(mk(6, 1, 1, 1));
    send_slot(mk(4, 127, 256, 0));
    send_slot(mk(4, 257, 256, 1));
    settle();

    // zero thresholds act on the first frame; the need write uses bit 8,
    // which the 8-bit register drops
    set_config(9'd0, 9'd511, 9'h100, 9'd0);
    send_slot(mk(2, 0, 1, 1));
    send_slot(mk(2, 2, 1, 1));
    send_slot(mk(3, 511, 256, 1));
    settle();

    // min above max: never filled
    set_config(9'd511, 9'd0, 9'd255, 9'd255);
    send_slot(mk(1, 65535, 1, 1));
    send_slot(mk(3, 0, 65535, 1));
    settle();

    // zero-width window at ratio zero
    set_config(9'd0, 9'd0, 9'd1, 9'd1);
    send_slot(mk(1, 0, 5, 0));
    send_slot(mk(0, 1, 65535, 0));
    send_slot(mk(3, 1, 1, 1));
    settle();

    // random phases, each with its own config and idling mix
    ph = 0;
    while (items_sent < RAND_ITEMS) begin
      in_idle  = ($urandom_range(0, 3) != 0);
      out_idle = ($urandom_range(0, 3) != 0);
      case (ph)
        0: set_config(MIN_FILL_RST, MAX_FILL_RST, 9'(ON_NEED_RST), 9'(OFF_NEED_RST));
        1: set_config(9'd0, 9'd511, 9'd0, 9'd0);
        2: begin
          // saturating runs with the widest thresholds
          set_config(9'd0, 9'd256, 9'd255, 9'd255);
          long_run(1, 1'b1);
          long_run(1, 1'b0);
        end
        default: begin
          min_q8 = RATIO_W'($urandom_range(0, 256));
          max_q8 = ($urandom_range(0, 3) == 0) ? RATIO_W'($urandom_range(0, 511))
                                               : RATIO_W'($urandom_range(min_q8, 511));
          set_config(min_q8, max_q8,
                     {1'($urandom_range(0, 1)), ($urandom_range(0, 7) == 0) ?
                      8'($urandom_range(0, 255)) : 8'($urandom_range(0, 4))},
                     {1'($urandom_range(0, 1)), ($urandom_range(0, 7) == 0) ?
                      8'($urandom_range(0, 255)) : 8'($urandom_range(0, 4))});
        end
      endcase
      if (ph == 3) begin
        // receiver stalls for a long stretch while slots keep coming back to back
        in_idle  = 1'b0;
        hold_req = 1'b1;
      end
      run_frames(10);
      // sender pauses until every owed meter has been delivered
      settle();
      run_frames(11);
      settle();
      ph++;
    end

    if (sb.errors == 0)
      $display("tb_slot_fill_debounce_meter: done, clean");
    else
      $display("tb_slot_fill_debounce_meter: done, errors");
    $finish;
  end

endmodule
